[design/mve_pkg.sv]
// Shared types and constants for the MessagePack value encoder.
`timescale 1ns / 1ps

package mve_pkg;

    localparam logic [3:0] CMD_UINT    = 4'd0;
    localparam logic [3:0] CMD_INT     = 4'd1;
    localparam logic [3:0] CMD_F32     = 4'd2;
    localparam logic [3:0] CMD_F64     = 4'd3;
    localparam logic [3:0] CMD_NIL     = 4'd4;
    localparam logic [3:0] CMD_FALSE   = 4'd5;
    localparam logic [3:0] CMD_TRUE    = 4'd6;
    localparam logic [3:0] CMD_STR     = 4'd7;
    localparam logic [3:0] CMD_BIN     = 4'd8;
    localparam logic [3:0] CMD_EXT     = 4'd9;
    localparam logic [3:0] CMD_ARRAY   = 4'd10;
    localparam logic [3:0] CMD_MAP     = 4'd11;
    localparam logic [3:0] CMD_PAYLOAD = 4'd12;

    localparam int MVE_QUEUE_DEPTH = 2;

    // One encoded item: a head byte, then count body bytes taken from the top of body.
    typedef struct packed {
        logic [7:0]  head;
        logic [63:0] body;
        logic [3:0]  count;
    } t_desc;

endpackage

[design/msgpack_value_encoder.sv]
// Top level of the MessagePack value encoder: classifier, queue, serializer.
//
//  channel  handshake                 payload
//  input    i_in_valid / o_in_ready   i_cmd, i_value, i_ext_kind
//  output   o_out_valid / i_out_ready o_out_byte, o_last
//
// One byte leaves per cycle while i_out_ready is high; an item is 1 to 9 encoded bytes,
// sent through the single output byte register of the serializer.
// Items with an unused cmd are taken and produce nothing.
// Reset clears the queue and the serializer; no clearing pass is needed.
// Output stalls back up through the queue to o_in_ready.
`timescale 1ns / 1ps

module msgpack_value_encoder
    import mve_pkg::*;
#(
    parameter int QUEUE_DEPTH = MVE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_cmd,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_ext_kind,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    localparam int DESC_W = $bits(t_desc);

    t_desc             fr_desc;
    t_desc             bk_desc;
    logic              fr_emit;
    logic              q_wr_ready;
    logic              q_rd_valid;
    logic              q_rd_ready;
    logic [DESC_W-1:0] q_rd_data;

    assign o_in_ready = q_wr_ready;
    assign bk_desc    = t_desc'(q_rd_data);

    mve_front u_front (
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .i_ext_kind (i_ext_kind),
        .o_emit     (fr_emit),
        .o_desc     (fr_desc)
    );

    mve_queue #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid && fr_emit),
        .o_wr_ready (q_wr_ready),
        .i_wr_data  (DESC_W'(fr_desc)),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (q_rd_ready),
        .o_rd_data  (q_rd_data)
    );

    mve_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (q_rd_valid),
        .o_desc_ready (q_rd_ready),
        .i_desc       (bk_desc),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

endmodule

[design/mve_queue.sv]
// Small register queue between the classifier and the byte serializer.
`timescale 1ns / 1ps

module mve_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

[design/mve_front.sv]
// Classifier: picks the shortest form of one value and builds its byte descriptor.
`timescale 1ns / 1ps

module mve_front
    import mve_pkg::*;
(
    input  logic [3:0]  i_cmd,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_ext_kind,
    output logic        o_emit,
    output t_desc       o_desc
);

    logic [31:0] len;
    logic [63:0] raw;
    logic [7:0]  head;
    logic [3:0]  count;
    logic [3:0]  pad;

    assign len = i_value[31:0];

    always_comb begin
        head   = 8'h00;
        raw    = i_value;
        count  = 4'd0;
        o_emit = 1'b1;
        case (i_cmd)
            CMD_UINT: begin
                if (i_value <= 64'h7f) begin
                    head = i_value[7:0];
                end else if (i_value <= 64'hff) begin
                    head = 8'hcc; count = 4'd1;
                end else if (i_value <= 64'hffff) begin
                    head = 8'hcd; count = 4'd2;
                end else if (i_value <= 64'hffff_ffff) begin
                    head = 8'hce; count = 4'd4;
                end else begin
                    head = 8'hcf; count = 4'd8;
                end
            end
            CMD_INT: begin
                if (!i_value[63]) begin
                    if (i_value <= 64'h7f) begin
                        head = i_value[7:0];
                    end else if (i_value <= 64'h7fff) begin
                        head = 8'hd1; count = 4'd2;
                    end else if (i_value <= 64'h7fff_ffff) begin
                        head = 8'hd2; count = 4'd4;
                    end else begin
                        head = 8'hd3; count = 4'd8;
                    end
                end else begin
                    if (&i_value[63:5]) begin
                        head = {3'b111, i_value[4:0]};
                    end else if (&i_value[63:7]) begin
                        head = 8'hd0; count = 4'd1;
                    end else if (&i_value[63:15]) begin
                        head = 8'hd1; count = 4'd2;
                    end else if (&i_value[63:31]) begin
                        head = 8'hd2; count = 4'd4;
                    end else begin
                        head = 8'hd3; count = 4'd8;
                    end
                end
            end
            CMD_F32: begin
                head = 8'hca; count = 4'd4;
            end
            CMD_F64: begin
                head = 8'hcb; count = 4'd8;
            end
            CMD_NIL:   head = 8'hc0;
            CMD_FALSE: head = 8'hc2;
            CMD_TRUE:  head = 8'hc3;
            CMD_STR: begin
                if (len <= 32'h1f) begin
                    head = {3'b101, len[4:0]};
                end else if (len <= 32'hff) begin
                    head = 8'hd9; count = 4'd1;
                end else if (len <= 32'hffff) begin
                    head = 8'hda; count = 4'd2;
                end else begin
                    head = 8'hdb; count = 4'd4;
                end
            end
            CMD_BIN: begin
                if (len <= 32'hff) begin
                    head = 8'hc4; count = 4'd1;
                end else if (len <= 32'hffff) begin
                    head = 8'hc5; count = 4'd2;
                end else begin
                    head = 8'hc6; count = 4'd4;
                end
            end
            CMD_EXT: begin
                raw = {24'h0, len, i_ext_kind};
                if (len == 32'd1) begin
                    head = 8'hd4; count = 4'd1;
                end else if (len == 32'd2) begin
                    head = 8'hd5; count = 4'd1;
                end else if (len == 32'd4) begin
                    head = 8'hd6; count = 4'd1;
                end else if (len == 32'd8) begin
                    head = 8'hd7; count = 4'd1;
                end else if (len == 32'd16) begin
                    head = 8'hd8; count = 4'd1;
                end else if (len <= 32'hff) begin
                    head = 8'hc7; count = 4'd2;
                end else if (len <= 32'hffff) begin
                    head = 8'hc8; count = 4'd3;
                end else begin
                    head = 8'hc9; count = 4'd5;
                end
            end
            CMD_ARRAY: begin
                if (len <= 32'hf) begin
                    head = {4'b1001, len[3:0]};
                end else if (len <= 32'hffff) begin
                    head = 8'hdc; count = 4'd2;
                end else begin
                    head = 8'hdd; count = 4'd4;
                end
            end
            CMD_MAP: begin
                if (len <= 32'hf) begin
                    head = {4'b1000, len[3:0]};
                end else if (len <= 32'hffff) begin
                    head = 8'hde; count = 4'd2;
                end else begin
                    head = 8'hdf; count = 4'd4;
                end
            end
            CMD_PAYLOAD: head = i_value[7:0];
            default:     o_emit = 1'b0;
        endcase
    end

    assign pad          = 4'd8 - count;
    assign o_desc.head  = head;
    assign o_desc.count = count;
    assign o_desc.body  = raw << {pad, 3'b000};

endmodule

[design/mve_back.sv]
// Serializer: sends the head byte and then the body bytes, one per cycle while i_out_ready allows.
`timescale 1ns / 1ps

module mve_back
    import mve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_desc_valid,
    output logic       o_desc_ready,
    input  t_desc      i_desc,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic        r_active;
    logic [63:0] r_body;
    logic [3:0]  r_left;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_last;
    logic        out_free;

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_desc_ready = out_free && !r_active;
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            if (r_active) begin
                r_out_valid <= 1'b1;
                r_active    <= (r_left != 4'd1);
            end else if (i_desc_valid) begin
                r_out_valid <= 1'b1;
                r_active    <= (i_desc.count != 4'd0);
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_active) begin
                r_out_byte <= r_body[63:56];
                r_last     <= (r_left == 4'd1);
                r_body     <= {r_body[55:0], 8'h00};
                r_left     <= r_left - 4'd1;
            end else if (i_desc_valid) begin
                r_out_byte <= i_desc.head;
                r_last     <= (i_desc.count == 4'd0);
                r_body     <= i_desc.body;
                r_left     <= i_desc.count;
            end
        end
    end

endmodule
